/* src/rational_arithmetic_unit_defines.svh */
// assertion macros for the rational arithmetic unit checker
// no dependencies
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau assertion failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau assertion failed");

`endif

/* src/rau_pkg.sv */
// shared types and codes for the rational arithmetic unit
// no dependencies
`default_nettype none

package rau_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_CHECK,
        S_GCD,
        S_GCD_WAIT,
        S_QN,
        S_QN_WAIT,
        S_QD,
        S_QD_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    localparam int RESULT_WIDTH = 32;

endpackage

`default_nettype wire

/* src/rau_if.sv */
// valid/ready channels carrying operand and result items
// no dependencies
`default_nettype none

interface rau_in_if #(parameter int OPERAND_WIDTH = 16);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      func;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_num;
    logic signed [31:0] result_den;
    logic               status;

    modport source (output valid, result_num, result_den, status, input ready);
    modport sink (input valid, result_num, result_den, status, output ready);
endinterface

`default_nettype wire

/* src/rau_div.sv */
// unsigned restoring divider, one quotient bit per cycle
// depends on rau_pkg
`default_nettype none

module rau_div #(
    parameter int WIDTH = 33
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [WIDTH-1:0]   dividend,
    input  wire logic [WIDTH-1:0]   divisor,
    output rau_pkg::div_stat_t      stat,
    output logic [WIDTH-1:0]        quot,
    output logic [WIDTH-1:0]        rem
);
    import rau_pkg::*;

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH-1:0] quot_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] div_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted = {rem_reg, quot_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_reg  <= diff[WIDTH-1:0];
                quot_reg <= {quot_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[WIDTH-1:0];
                quot_reg <= {quot_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;
    assign rem       = rem_reg;

endmodule

`default_nettype wire

/* src/rational_arithmetic_unit.sv */
// top level of the rational arithmetic unit: sequencer, shared multiplier, gcd loop
// depends on rau_pkg, rau_if and rau_div
//
// usage: operand items (func, a_num/a_den, b_num/b_den) arrive on the operands
// channel, result items (result_num, result_den, status) leave on the result
// channel; both are valid/ready, an item moves when valid and ready are high.
// one item is worked on at a time; operands.ready is high only when idle.
// one shared signed multiplier forms the three cross products, then a shared
// restoring divider (one bit per cycle, N = min(2*OPERAND_WIDTH+1, 64) bits
// wide) runs the euclid remainder loop and the two final divisions; with
// 16-bit operands, N = 33.
// a zero denominator or a divide by a zero numerator skips the divider and
// gives a result with status set and zero fields.
// the result is held in an output register; a new item is accepted while it
// waits, and a finished item waits in the sequencer if the register is full.
// reset clears the sequencer and the result valid flag; no item is pending.
`default_nettype none

module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rau_in_if.sink     operands,
    rau_out_if.source  result
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int NW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
    localparam int EW = (NW > RESULT_WIDTH) ? NW : RESULT_WIDTH;

    state_t state_reg;
    state_t state_next;

    logic [1:0]          op_reg;
    logic signed [W-1:0] an_reg;
    logic signed [W-1:0] ad_reg;
    logic signed [W-1:0] bn_reg;
    logic signed [W-1:0] bd_reg;
    logic                err_reg;

    logic signed [NW-1:0] num_reg;
    logic signed [NW-1:0] den_reg;
    logic signed [NW-1:0] x_reg;
    logic signed [NW-1:0] y_reg;
    logic signed [NW-1:0] g_reg;
    logic signed [NW-1:0] qn_reg;
    logic signed [NW-1:0] qd_reg;

    logic               res_valid_reg;
    logic signed [31:0] res_num_reg;
    logic signed [31:0] res_den_reg;
    logic               res_status_reg;

    logic                  in_fire;
    logic                  in_err;
    logic                  out_free;
    logic signed [W-1:0]   mul_a;
    logic signed [W-1:0]   mul_b;
    logic signed [2*W-1:0] prod;
    logic signed [NW-1:0]  prod_ext;

    logic                 div_start;
    logic [NW-1:0]        div_dividend;
    logic [NW-1:0]        div_divisor;
    div_stat_t            div_stat;
    logic [NW-1:0]        div_quot;
    logic [NW-1:0]        div_rem;
    logic signed [NW-1:0] rem_signed;
    logic                 q_neg;
    logic signed [NW-1:0] q_signed;
    logic signed [EW-1:0] qn_ext;
    logic signed [EW-1:0] qd_ext;

    function automatic logic [NW-1:0] mag(input logic signed [NW-1:0] v);
        return v[NW-1] ? NW'(-v) : NW'(v);
    endfunction

    assign in_fire  = operands.valid && operands.ready;
    assign in_err   = (operands.a_den == '0) || (operands.b_den == '0)
                      || ((operands.func == FUNC_DIV) && (operands.b_num == '0));
    assign out_free = !res_valid_reg || result.ready;

    // shared multiplier
    assign prod     = mul_a * mul_b;
    assign prod_ext = NW'(prod);

    assign rem_signed = x_reg[NW-1] ? NW'(-div_rem) : NW'(div_rem);
    assign q_signed   = q_neg ? NW'(-div_quot) : NW'(div_quot);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_fire) state_next = in_err ? S_FINISH : S_MUL0;
            S_MUL0:     state_next = S_MUL1;
            S_MUL1:     state_next = S_MUL2;
            S_MUL2:     state_next = S_CHECK;
            S_CHECK:    state_next = (den_reg == '0) ? S_FINISH : S_GCD;
            S_GCD:      state_next = S_GCD_WAIT;
            S_GCD_WAIT: if (div_stat.done) state_next = (rem_signed == '0) ? S_QN : S_GCD;
            S_QN:       state_next = S_QN_WAIT;
            S_QN_WAIT:  if (div_stat.done) state_next = S_QD;
            S_QD:       state_next = S_QD_WAIT;
            S_QD_WAIT:  if (div_stat.done) state_next = S_FINISH;
            S_FINISH:   if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        operands.ready = 1'b0;
        div_start      = 1'b0;
        div_dividend   = mag(den_reg);
        div_divisor    = mag(g_reg);
        mul_a          = an_reg;
        mul_b          = bd_reg;
        q_neg          = den_reg[NW-1] ^ g_reg[NW-1];
        case (state_reg)
            S_IDLE:
            begin
                operands.ready = 1'b1;
            end
            S_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == FUNC_MUL) ? bn_reg : bd_reg;
            end
            S_MUL1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            S_MUL2:
            begin
                mul_a = ad_reg;
                mul_b = (op_reg == FUNC_DIV) ? bn_reg : bd_reg;
            end
            S_GCD:
            begin
                div_start    = 1'b1;
                div_dividend = mag(x_reg);
                div_divisor  = mag(y_reg);
            end
            S_QN:
            begin
                div_start    = 1'b1;
                div_dividend = mag(num_reg);
            end
            S_QN_WAIT:
            begin
                q_neg = num_reg[NW-1] ^ g_reg[NW-1];
            end
            S_QD:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                operands.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_FINISH) && out_free)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_reg  <= operands.func;
                    an_reg  <= operands.a_num;
                    ad_reg  <= operands.a_den;
                    bn_reg  <= operands.b_num;
                    bd_reg  <= operands.b_den;
                    err_reg <= in_err;
                end
            end
            S_MUL0:
            begin
                num_reg <= prod_ext;
            end
            S_MUL1:
            begin
                if (op_reg == FUNC_ADD)
                    num_reg <= num_reg + prod_ext;
                else if (op_reg == FUNC_SUB)
                    num_reg <= num_reg - prod_ext;
            end
            S_MUL2:
            begin
                den_reg <= prod_ext;
            end
            S_CHECK:
            begin
                x_reg <= num_reg;
                y_reg <= den_reg;
                if (den_reg == '0)
                    err_reg <= 1'b1;
            end
            S_GCD_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (rem_signed == '0)
                        g_reg <= y_reg;
                    else
                    begin
                        x_reg <= y_reg;
                        y_reg <= rem_signed;
                    end
                end
            end
            S_QN_WAIT:
            begin
                if (div_stat.done)
                    qn_reg <= q_signed;
            end
            S_QD_WAIT:
            begin
                if (div_stat.done)
                    qd_reg <= q_signed;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    res_status_reg <= err_reg;
                    res_num_reg    <= err_reg ? '0 : qn_ext[31:0];
                    res_den_reg    <= err_reg ? '0 : qd_ext[31:0];
                end
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    assign qn_ext = EW'(qn_reg);
    assign qd_ext = EW'(qd_reg);

    rau_div #(
        .WIDTH (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign result.valid      = res_valid_reg;
    assign result.result_num = res_num_reg;
    assign result.result_den = res_den_reg;
    assign result.status     = res_status_reg;

endmodule

`default_nettype wire

/* src/rau_checker.sv */
// port-level checks for the rational arithmetic unit, bound to the top level
// depends on rational_arithmetic_unit_defines.svh and rational_arithmetic_unit
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"

module rau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_num,
    input wire logic [31:0] out_den,
    input wire logic        out_status
);
    // busy after taking an item
    `RAU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // an error result carries zero fields
    `RAU_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_status,
                    (out_num == 32'd0) && (out_den == 32'd0))
    // an ok result never has a zero denominator
    `RAU_ASSERT_NOW(a_ok_den, clk, rst_n, out_valid && !out_status, out_den != 32'd0)
    // a stalled result holds
    `RAU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(out_num) && $stable(out_den) && $stable(out_status))
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (operands.valid),
    .in_ready   (operands.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_num    (result.result_num),
    .out_den    (result.result_den),
    .out_status (result.status)
);

`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench for the rational arithmetic unit
// depends on rau_pkg, rau_if and rational_arithmetic_unit
// directed and random fraction items are checked against a built-in predictor
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int OPW = 16;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic               status;
    } fraction_t;

    logic clk;
    logic rst_n;

    rau_in_if #(.OPERAND_WIDTH(OPW)) op_if ();
    rau_out_if res_if ();

    rational_arithmetic_unit #(.OPERAND_WIDTH(OPW)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (op_if.sink),
        .result   (res_if.source)
    );

    fraction_t expected_fractions[$];
    int        errors = 0;
    int        hold_cycles = 0;
    int        burst_left = 0;
    int        idle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint rem_trunc(longint x, longint y);
        if (y == 1 || y == -1)
            return 0;
        return x % y;
    endfunction

    function automatic longint div_trunc(longint x, longint y);
        if (y == -1)
            return -x;
        return x / y;
    endfunction

    function automatic fraction_t reduce_fraction(func_t f, logic signed [OPW-1:0] an,
                                                  logic signed [OPW-1:0] ad,
                                                  logic signed [OPW-1:0] bn,
                                                  logic signed [OPW-1:0] bd);
        fraction_t res;
        longint    n;
        longint    d;
        longint    x;
        longint    y;
        longint    r;
        longint    q;
        res.num = '0;
        res.den = '0;
        res.status = 1'b1;
        if (ad == 0 || bd == 0 || (f == FUNC_DIV && bn == 0))
            return res;
        case (f)
            FUNC_ADD:
            begin
                n = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
                d = longint'(ad) * longint'(bd);
            end
            FUNC_SUB:
            begin
                n = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
                d = longint'(ad) * longint'(bd);
            end
            FUNC_MUL:
            begin
                n = longint'(an) * longint'(bn);
                d = longint'(ad) * longint'(bd);
            end
            default:
            begin
                n = longint'(an) * longint'(bd);
                d = longint'(ad) * longint'(bn);
            end
        endcase
        if (d == 0)
            return res;
        x = n;
        y = d;
        r = rem_trunc(x, y);
        while (r != 0)
        begin
            x = y;
            y = r;
            r = rem_trunc(x, y);
        end
        q = div_trunc(n, y);
        res.num = q[31:0];
        q = div_trunc(d, y);
        res.den = q[31:0];
        res.status = 1'b0;
        return res;
    endfunction

    // one item on the operand channel, then a random gap between bursts
    task automatic send_item(func_t f, logic signed [OPW-1:0] an, logic signed [OPW-1:0] ad,
                             logic signed [OPW-1:0] bn, logic signed [OPW-1:0] bd);
        int gap;
        op_if.valid <= 1'b1;
        op_if.func  <= f;
        op_if.a_num <= an;
        op_if.a_den <= ad;
        op_if.b_num <= bn;
        op_if.b_den <= bd;
        do
            @(posedge clk);
        while (!op_if.ready);
        expected_fractions.push_back(reduce_fraction(f, an, ad, bn, bd));
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 8);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                op_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        op_if.valid <= 1'b0;
        while (expected_fractions.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [OPW-1:0] pick_operand(bit allow_zero);
        logic signed [OPW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = allow_zero ? '0 : 16'sd1;
            1: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8001;
            2: v = 16'sh8000;
            3, 4: v = $urandom_range(0, 1) ? $urandom_range(1, 12) : -$urandom_range(1, 12);
            5, 6: v = $urandom_range(0, 1) ? $urandom_range(1, 400) : -$urandom_range(1, 400);
            default: v = $urandom;
        endcase
        if (!allow_zero && v == 0)
            v = 16'sd3;
        return v;
    endfunction

    task automatic test_directed();
        send_item(FUNC_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_item(FUNC_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_item(FUNC_MUL, 16'sd2, 16'sd3, 16'sd9, 16'sd4);
        send_item(FUNC_DIV, 16'sd2, 16'sd3, 16'sd4, 16'sd9);
        send_item(FUNC_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(FUNC_SUB, 16'sh8001, 16'sh7fff, 16'sh7fff, 16'sh8001);
        send_item(FUNC_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_item(FUNC_DIV, 16'sh7fff, 16'sh8000, 16'sh8001, 16'sh7ffe);
        send_item(FUNC_ADD, 16'sd5, 16'sd0, 16'sd1, 16'sd2);
        send_item(FUNC_MUL, 16'sd5, 16'sd3, 16'sd1, 16'sd0);
        send_item(FUNC_SUB, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_item(FUNC_DIV, 16'sd7, 16'sd3, 16'sd0, 16'sd5);
        send_item(FUNC_MUL, 16'sd0, 16'sd7, 16'sd3, 16'sd5);
        send_item(FUNC_ADD, 16'sd0, -16'sd7, 16'sd0, 16'sd5);
        send_item(FUNC_DIV, 16'sd0, 16'sd7, 16'sd3, 16'sd5);
        send_item(FUNC_MUL, 16'sd3, -16'sd7, 16'sd5, 16'sd2);
        send_item(FUNC_ADD, -16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_item(FUNC_MUL, 16'sd1, -16'sd1, 16'sd1, 16'sd1);
        send_item(FUNC_DIV, -16'sd1, 16'sd1, 16'sd1, -16'sd1);
        send_item(FUNC_SUB, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
        send_item(FUNC_MUL, 16'sd7, 16'sd5, 16'sd11, 16'sd3);
        send_item(FUNC_ADD, 16'sh5555, 16'shaaaa, 16'sh2aaa, 16'sh1234);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (8)
            send_item(func_t'($urandom_range(0, 3)), pick_operand(1), pick_operand(0),
                      pick_operand(0), pick_operand(0));
    endtask

    task automatic test_drain_pause();
        wait_drained();
        repeat (5)
            send_item(func_t'($urandom_range(0, 3)), pick_operand(1), pick_operand(0),
                      pick_operand(0), pick_operand(0));
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(func_t'($urandom_range(0, 3)), pick_operand(1), pick_operand(1),
                          pick_operand(1), pick_operand(1));
            else
                send_item(func_t'($urandom_range(0, 3)), pick_operand(1), pick_operand(0),
                          pick_operand(1), pick_operand(0));
        end
    endtask

    // receiver ready: a hold-off while hold_cycles is set, then a pattern drawn at random at the start of each phase
    initial
    begin
        int mode;
        int phase;
        res_if.ready = 1'b0;
        mode = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                if (phase == 0)
                    mode = $urandom_range(0, 3);
                phase = (phase + 1) % 64;
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= $urandom_range(0, 1);
                    2: res_if.ready <= $urandom_range(0, 7) == 0;
                    default: res_if.ready <= phase[2];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        fraction_t exp_f;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_fractions.size() == 0)
            begin
                $display("%0t: unexpected result item %0d/%0d status %0b", $realtime,
                         res_if.result_num, res_if.result_den, res_if.status);
                errors++;
            end
            else
            begin
                exp_f = expected_fractions.pop_front();
                if (res_if.result_num !== exp_f.num)
                begin
                    $display("%0t: result_num expected %0d actual %0d", $realtime,
                             exp_f.num, res_if.result_num);
                    errors++;
                end
                if (res_if.result_den !== exp_f.den)
                begin
                    $display("%0t: result_den expected %0d actual %0d", $realtime,
                             exp_f.den, res_if.result_den);
                    errors++;
                end
                if (res_if.status !== exp_f.status)
                begin
                    $display("%0t: status expected %0b actual %0b", $realtime,
                             exp_f.status, res_if.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready) || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        op_if.valid = 1'b0;
        op_if.func  = FUNC_ADD;
        op_if.a_num = '0;
        op_if.a_den = '0;
        op_if.b_num = '0;
        op_if.b_den = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(1510);
        wait_drained();
        repeat (2000) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* rational_arithmetic_unit.f */
+incdir+src
src/rau_pkg.sv
src/rau_if.sv
src/rau_div.sv
src/rational_arithmetic_unit.sv
src/rau_checker.sv
test/tb_top.sv
